// File: hw/rtl/pspt_pkg.sv
package pspt_pkg;

	// number of source slots in the chain
	localparam int unsigned TABLE_ENTRIES = 32;

	// item modes
	localparam logic [1:0] MODE_REPORT = 2'd0;
	localparam logic [1:0] MODE_AWAKE  = 2'd1;
	localparam logic [1:0] MODE_WINDOW = 2'd2;

	localparam logic [3:0] WARN_LIMIT_RST = 4'd3;

	// threshold scaled by 1e4: p(x) = 2950 + 29400 x - 560 x^2 + 6 x^3, x in 1..256
	localparam int unsigned POLY_W  = 28;
	localparam logic [POLY_W-1:0] POLY_C0 = 28'd2950;
	localparam logic [POLY_W-1:0] POLY_C1 = 28'd29400;
	localparam logic [POLY_W-1:0] POLY_C2 = 28'd560;
	localparam logic [POLY_W-1:0] POLY_C3 = 28'd6;

	// floor(p / 10000) as (p * RECIP) >> RECIP_SHIFT, exact for p < 2^27
	localparam int unsigned PROD_W      = 54;
	localparam int unsigned RECIP_SHIFT = 40;
	localparam logic [26:0] RECIP       = 27'd109951163;

	// integer threshold, at most 7149
	localparam int unsigned THR_W = 13;

	localparam logic [15:0] COUNT_MAX = 16'hFFFF;
	localparam logic [7:0]  TOTAL_MAX = 8'hFF;

	// token that walks the chain, one cell per cycle
	typedef struct packed {
		logic             vld;
		logic [1:0]       mode;
		logic [7:0]       id;
		logic [THR_W-1:0] thr;
		logic             done;  // report already handled by an earlier cell
		logic             pen;   // report penalised its source
		logic             ins;   // report inserted a new source
	} tok_t;

endpackage

// File: hw/rtl/pspt_ifs.sv
interface pspt_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic [7:0] source_id;
	logic [7:0] report_value;

	modport source (output valid, mode, source_id, report_value, input ready);
	modport sink (input valid, mode, source_id, report_value, output ready);
endinterface

interface pspt_result_if;
	logic       valid;
	logic       ready;
	logic       penalise;
	logic [7:0] source_total;

	modport source (output valid, penalise, source_total, input ready);
	modport sink (input valid, penalise, source_total, output ready);
endinterface

// File: hw/rtl/pspt_thresh.sv
module pspt_thresh (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [1:0]           mode,
	input  logic [7:0]           source_id,
	input  logic [7:0]           report_value,
	output pspt_pkg::tok_t       tok
);

	logic        vld_s1, vld_s2, vld_s3;
	logic [1:0]  mode_s1, mode_s2, mode_s3;
	logic [7:0]  id_s1, id_s2, id_s3;
	logic [8:0]  x_s1;
	logic [16:0] sq_s1;
	logic [24:0] cube_s2;
	logic [pspt_pkg::POLY_W-1:0] lin_s2;
	logic [pspt_pkg::POLY_W-1:0] p_s3;
	logic [8:0]  x_in;
	logic [pspt_pkg::PROD_W-1:0] prod;

	assign x_in = {1'b0, report_value} + 9'd1;
	assign prod = pspt_pkg::PROD_W'(p_s3) * pspt_pkg::PROD_W'(pspt_pkg::RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			tok    <= '0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			tok.vld <= vld_s3;
			tok.mode <= mode_s3;
			tok.id <= id_s3;
			tok.thr <= prod[pspt_pkg::RECIP_SHIFT +: pspt_pkg::THR_W];
			tok.done <= 1'b0;
			tok.pen <= 1'b0;
			tok.ins <= 1'b0;
		end
	end

	// payload stages
	always_ff @(posedge clk) begin
		mode_s1 <= mode;
		id_s1   <= source_id;
		x_s1    <= x_in;
		sq_s1   <= 17'(x_in) * 17'(x_in);

		mode_s2 <= mode_s1;
		id_s2   <= id_s1;
		cube_s2 <= 25'(sq_s1) * 25'(x_s1);
		// modular arithmetic, the final sum is positive
		lin_s2  <= pspt_pkg::POLY_C0
			+ pspt_pkg::POLY_W'(x_s1) * pspt_pkg::POLY_C1
			- pspt_pkg::POLY_W'(sq_s1) * pspt_pkg::POLY_C2;

		mode_s3 <= mode_s2;
		id_s3   <= id_s2;
		p_s3    <= lin_s2 + pspt_pkg::POLY_W'(cube_s2) * pspt_pkg::POLY_C3;
	end

endmodule

// File: hw/rtl/pspt_cell.sv
module pspt_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [3:0]     warn_limit,
	input  pspt_pkg::tok_t tok_in,
	output pspt_pkg::tok_t tok_out
);

	logic [7:0]  id_q, id_n;
	logic [15:0] cnt_q, cnt_n, cnt_inc;
	logic [3:0]  warn_q, warn_n;
	logic        pen_q, pen_n;
	logic [4:0]  warn_inc;
	pspt_pkg::tok_t tok_n;

	assign cnt_inc  = (cnt_q == pspt_pkg::COUNT_MAX) ? cnt_q : cnt_q + 16'd1;
	assign warn_inc = {1'b0, warn_q} + 5'd1;

	always_comb begin
		tok_n  = tok_in;
		id_n   = id_q;
		cnt_n  = cnt_q;
		warn_n = warn_q;
		pen_n  = pen_q;
		if (tok_in.vld && !tok_in.done) begin
			case (tok_in.mode)
				pspt_pkg::MODE_REPORT: begin
					if (id_q == 8'd0) begin
						// empty slot comes first: insert
						id_n      = tok_in.id;
						cnt_n     = 16'd1;
						tok_n.done = 1'b1;
						tok_n.ins  = 1'b1;
					end else if (id_q == tok_in.id) begin
						tok_n.done = 1'b1;
						if (cnt_inc > 16'(tok_in.thr)) begin
							cnt_n = 16'd0;
							if (warn_inc > {1'b0, warn_limit}) begin
								warn_n    = 4'd0;
								pen_n     = 1'b1;
								tok_n.pen = 1'b1;
							end else begin
								warn_n = warn_inc[3:0];
							end
						end else begin
							cnt_n = cnt_inc;
						end
					end
				end
				pspt_pkg::MODE_AWAKE: begin
					if (id_q == tok_in.id) begin
						pen_n = 1'b0;
					end
				end
				pspt_pkg::MODE_WINDOW: begin
					cnt_n  = 16'd0;
					warn_n = 4'd0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_q    <= 8'd0;
			cnt_q   <= 16'd0;
			warn_q  <= 4'd0;
			pen_q   <= 1'b0;
			tok_out <= '0;
		end else begin
			id_q    <= id_n;
			cnt_q   <= cnt_n;
			warn_q  <= warn_n;
			pen_q   <= pen_n;
			tok_out <= tok_n;
		end
	end

endmodule

// File: hw/rtl/per_source_rate_penalty_table_top.sv
// channel   dir   payload                              transfer when
// item      in    mode, source_id, report_value        item.valid && item.ready
// result    out   penalise, source_total               result.valid && result.ready
// cfg       in    cfg_wdata = warning_limit            cfg_we high
//
// one item at a time: an item passes the threshold stages, one register per slot cell
// and then the result register; item.ready stays low from the item transfer until
// the token drops off the end of the chain
// reset clears every slot, the source total and sets warning_limit to 3
// a result waiting on result.ready does not hold off the next item; a second
// finished result parks in a holding register and then item.ready drops
module per_source_rate_penalty_table_top (
	input  logic                clk,
	input  logic                arst_n,
	pspt_item_if.sink           item,
	pspt_result_if.source       result,
	input  logic                cfg_we,
	input  logic [3:0]          cfg_wdata
);

	localparam int unsigned N = pspt_pkg::TABLE_ENTRIES;

	logic       busy_q;
	logic       accept;
	logic [3:0] warn_limit_q;
	logic [7:0] total_q, total_new;

	// result register and its holding slot
	logic       out_vld_q, out_pen_q;
	logic [7:0] out_tot_q;
	logic       hold_vld_q, hold_pen_q;
	logic [7:0] hold_tot_q;
	logic       out_free;

	// token taps between cells, tap 0 from the threshold pipeline
	pspt_pkg::tok_t tok [N+1];
	pspt_pkg::tok_t tail;

	assign item.ready = !busy_q && !hold_vld_q;
	assign accept     = item.valid && item.ready;
	assign tail       = tok[N];
	assign out_free   = !out_vld_q || result.ready;

	// source total after this item, saturating
	assign total_new = (tail.ins && total_q != pspt_pkg::TOTAL_MAX) ? total_q + 8'd1 : total_q;

	assign result.valid        = out_vld_q;
	assign result.penalise     = out_pen_q;
	assign result.source_total = out_tot_q;

	// cubic threshold, scaled and divided down to an integer count
	pspt_thresh u_thresh (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (accept),
		.mode         (item.mode),
		.source_id    (item.source_id),
		.report_value (item.report_value),
		.tok          (tok[0])
	);

	// one cell per slot, the token steps one cell each cycle in slot order
	for (genvar g = 0; g < N; g++) begin : g_cell
		pspt_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.warn_limit (warn_limit_q),
			.tok_in     (tok[g]),
			.tok_out    (tok[g+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warn_limit_q <= pspt_pkg::WARN_LIMIT_RST;
		end else if (cfg_we) begin
			warn_limit_q <= cfg_wdata;
		end
	end

	// busy from item transfer until the token drops off the end of the chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			total_q <= 8'd0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (tail.vld) begin
				busy_q <= 1'b0;
			end
			if (tail.vld) begin
				total_q <= total_new;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			hold_vld_q <= 1'b0;
		end else begin
			if (tail.vld) begin
				if (out_free) begin
					out_vld_q <= 1'b1;
				end else begin
					hold_vld_q <= 1'b1;
				end
			end else if (out_free) begin
				// move a parked result up, or go empty
				out_vld_q  <= hold_vld_q;
				hold_vld_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (tail.vld) begin
			if (out_free) begin
				out_pen_q <= tail.pen;
				out_tot_q <= total_new;
			end else begin
				hold_pen_q <= tail.pen;
				hold_tot_q <= total_new;
			end
		end else if (out_free && hold_vld_q) begin
			out_pen_q <= hold_pen_q;
			out_tot_q <= hold_tot_q;
		end
	end

endmodule

// File: test/per_source_rate_penalty_table_top_tb.sv
module per_source_rate_penalty_table_top_tb;

	// mode code the block leaves unused, it still answers with a result
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	// token walks every slot cell plus the threshold pipeline and result register
	localparam int unsigned DRAIN_CYCLES = pspt_pkg::TABLE_ENTRIES + 8;

	// expected content of one result transfer
	typedef struct packed {
		logic       penalise;
		logic [7:0] source_total;
	} outcome_t;

	// mirror of the source table, predicts each result in transfer order
	class penalty_scoreboard;
		logic [7:0]  slot_id [pspt_pkg::TABLE_ENTRIES];
		logic [15:0] slot_count [pspt_pkg::TABLE_ENTRIES];
		logic [3:0]  slot_warnings [pspt_pkg::TABLE_ENTRIES];
		logic        slot_penalised [pspt_pkg::TABLE_ENTRIES];
		logic [7:0]  source_total;
		logic [3:0]  warning_limit;
		outcome_t    outcome_q[$];
		int          errors;

		function new();
			for (int i = 0; i < pspt_pkg::TABLE_ENTRIES; i++) begin
				slot_id[i]        = '0;
				slot_count[i]     = '0;
				slot_warnings[i]  = '0;
				slot_penalised[i] = 1'b0;
			end
			source_total  = '0;
			warning_limit = pspt_pkg::WARN_LIMIT_RST;
			errors        = 0;
		endfunction

		function void set_limit(logic [3:0] limit);
			warning_limit = limit;
		endfunction

		function int pending();
			return outcome_q.size();
		endfunction

		// traffic report: insert at the first empty slot or bump the matching one
		function bit apply_report(logic [7:0] id, logic [7:0] value);
			longint     x;
			longint     bound;
			logic [4:0] warn_next;
			x     = longint'(value) + 1;
			bound = 2950 + 29400 * x - 560 * x * x + 6 * x * x * x;
			for (int i = 0; i < pspt_pkg::TABLE_ENTRIES; i++) begin
				if (slot_id[i] == 8'd0) begin
					slot_id[i]    = id;
					slot_count[i] = 16'd1;
					if (source_total != pspt_pkg::TOTAL_MAX)
						source_total = source_total + 8'd1;
					return 1'b0;
				end
				if (slot_id[i] == id) begin
					if (slot_count[i] != pspt_pkg::COUNT_MAX)
						slot_count[i] = slot_count[i] + 16'd1;
					if (longint'(slot_count[i]) * 10000 > bound) begin
						warn_next     = {1'b0, slot_warnings[i]} + 5'd1;
						slot_count[i] = '0;
						if (warn_next > {1'b0, warning_limit}) begin
							slot_warnings[i]  = '0;
							slot_penalised[i] = 1'b1;
							return 1'b1;
						end
						slot_warnings[i] = warn_next[3:0];
					end
					return 1'b0;
				end
			end
			return 1'b0;
		endfunction

		function void note_item(logic [1:0] mode, logic [7:0] id, logic [7:0] value);
			outcome_t o;
			o.penalise = 1'b0;
			case (mode)
				pspt_pkg::MODE_REPORT: o.penalise = apply_report(id, value);
				pspt_pkg::MODE_AWAKE: begin
					for (int i = 0; i < pspt_pkg::TABLE_ENTRIES; i++)
						if (slot_id[i] == id)
							slot_penalised[i] = 1'b0;
				end
				pspt_pkg::MODE_WINDOW: begin
					for (int i = 0; i < pspt_pkg::TABLE_ENTRIES; i++) begin
						slot_count[i]    = '0;
						slot_warnings[i] = '0;
					end
				end
				default: ;
			endcase
			o.source_total = source_total;
			outcome_q.push_back(o);
		endfunction

		function void check_result(logic penalise, logic [7:0] total);
			outcome_t o;
			if (outcome_q.size() == 0) begin
				$error("unexpected result: penalise %0b source_total %0d", penalise, total);
				errors++;
				return;
			end
			o = outcome_q.pop_front();
			if (penalise !== o.penalise) begin
				$error("penalise: expected %0b actual %0b", o.penalise, penalise);
				errors++;
			end
			if (total !== o.source_total) begin
				$error("source_total: expected %0d actual %0d", o.source_total, total);
				errors++;
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [3:0] cfg_wdata;
	bit         calm = 1'b0;   // set for the last part: no gaps, no stalls

	penalty_scoreboard scoreboard;

	pspt_item_if   item_if();
	pspt_result_if result_if();

	per_source_rate_penalty_table_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_if),
		.result    (result_if),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// hard stop in case the block hangs
	initial begin
		#4000000;
		$display("simulation failed");
		$finish;
	end

	// watch both channels; values sampled here are the ones the block sees at this edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_if.valid && result_if.ready)
				scoreboard.check_result(result_if.penalise, result_if.source_total);
			if (item_if.valid && item_if.ready)
				scoreboard.note_item(item_if.mode, item_if.source_id, item_if.report_value);
		end
	end

	// result side: ready in random bursts, with random stalls between them
	initial begin
		result_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (calm || $urandom_range(0, 2) != 0) begin
				result_if.ready <= 1'b1;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end else begin
				result_if.ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end
		end
	end

	// one item transfer, with an occasional gap before it
	task automatic send_item(input logic [1:0] mode, input logic [7:0] id,
			input logic [7:0] value);
		if (!calm && $urandom_range(0, 3) == 0) begin
			item_if.valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		item_if.valid        <= 1'b1;
		item_if.mode         <= mode;
		item_if.source_id    <= id;
		item_if.report_value <= value;
		do @(posedge clk); while (!item_if.ready);
	endtask

	// mostly reports on a small id pool with low values so sources hit their thresholds
	task automatic send_random(input int unsigned pool_hi, input int unsigned zero_pct,
			input int unsigned wide_pct, input int unsigned window_pct);
		int unsigned pick;
		logic [1:0]  mode;
		logic [7:0]  id;
		logic [7:0]  value;
		pick  = $urandom_range(0, 99);
		value = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
			: 8'($urandom_range(0, 3));
		if ($urandom_range(0, 99) < zero_pct)
			id = 8'd0;
		else if ($urandom_range(0, 99) < wide_pct)
			id = 8'($urandom_range(1, 255));
		else
			id = 8'($urandom_range(1, pool_hi));
		if (pick < window_pct)
			mode = pspt_pkg::MODE_WINDOW;
		else if (pick < window_pct + 3)
			mode = pspt_pkg::MODE_AWAKE;
		else if (pick < window_pct + 4)
			mode = MODE_UNUSED;
		else
			mode = pspt_pkg::MODE_REPORT;
		send_item(mode, id, value);
	endtask

	task automatic run_phase(input int unsigned count, input int unsigned pool_hi,
			input int unsigned zero_pct, input int unsigned wide_pct,
			input int unsigned window_pct);
		repeat (count) send_random(pool_hi, zero_pct, wide_pct, window_pct);
		item_if.valid <= 1'b0;
	endtask

	// register write only once the block has drained
	task automatic write_limit(input logic [3:0] limit);
		while (scoreboard.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_wdata <= limit;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we    <= 1'b0;
		scoreboard.set_limit(limit);
	endtask

	initial begin
		scoreboard = new();
		arst_n               <= 1'b0;
		cfg_we               <= 1'b0;
		cfg_wdata            <= '0;
		item_if.valid        <= 1'b0;
		item_if.mode         <= pspt_pkg::MODE_REPORT;
		item_if.source_id    <= '0;
		item_if.report_value <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, reset warning limit
		// id 0 takes an empty slot, slot stays empty
		send_item(pspt_pkg::MODE_REPORT, 8'd0, 8'd0);
		send_item(pspt_pkg::MODE_REPORT, 8'd255, 8'd255);
		send_item(pspt_pkg::MODE_REPORT, 8'd255, 8'd255);
		send_item(MODE_UNUSED, 8'hAA, 8'h55);      // ignored mode still yields a result
		send_item(pspt_pkg::MODE_AWAKE, 8'd200, 8'd0);       // awake on an absent id
		// three warnings, then penalty
		repeat (16) send_item(pspt_pkg::MODE_REPORT, 8'd1, 8'd0);
		send_item(pspt_pkg::MODE_AWAKE, 8'd1, 8'hFF);
		send_item(pspt_pkg::MODE_AWAKE, 8'd0, 8'd0);         // awake on the empty marker
		send_item(pspt_pkg::MODE_WINDOW, 8'd0, 8'd0);
		item_if.valid <= 1'b0;

		// limit 0: first warning penalises
		write_limit(4'd0);
		run_phase(300, 6, 25, 0, 2);

		// limit 15: long warning runs, no window clears, many id 0 inserts
		// push the total into saturation
		write_limit(4'd15);
		run_phase(400, 2, 50, 0, 0);

		// wide ids fill the table, later reports on absent ids change nothing
		write_limit(4'd9);
		run_phase(450, 8, 5, 30, 1);

		// last part runs without gaps or stalls
		write_limit(4'd1);
		calm = 1'b1;
		run_phase(600, 8, 5, 10, 1);

		while (scoreboard.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (scoreboard.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/pspt_pkg.sv
hw/rtl/pspt_ifs.sv
hw/rtl/pspt_thresh.sv
hw/rtl/pspt_cell.sv
hw/rtl/per_source_rate_penalty_table_top.sv
test/per_source_rate_penalty_table_top_tb.sv
